// ===== src/integer_matrix_multiply_core_macros.svh =====
// assertion macros for the integer matrix multiply core
`ifndef INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_CORE_MACROS_SVH

// property checked on every clock edge outside reset
`define IMM_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("imm assertion failed");

// property checked on every clock edge, reset included
`define IMM_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("imm assertion failed");

`endif

// ===== src/imm_pkg.sv =====
// shared types and constants of the integer matrix multiply core
`default_nettype none

package imm_pkg;

    localparam int DATA_W    = 32;  // entry and product width
    localparam int DIM_W     = 4;   // size register width
    localparam int POS_W     = 3;   // row and column field width
    localparam int ACT_W     = 2;   // action field width
    localparam int CFG_IDX_W = 2;   // config register index width

    // actions
    localparam logic [ACT_W-1:0] ACT_WR_A  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_WR_B  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_START = 2'd2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_B = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;

    // one dot product term issued to the mac
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_term;

endpackage

`default_nettype wire

// ===== src/imm_store.sv =====
// matrix A and B stores, one write port, synchronous read of one A and one B entry
`default_nettype none

module imm_store #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic                       i_wr_sel_b,
    input  wire logic [ADDR_W-1:0]          i_wr_addr,
    input  wire logic [imm_pkg::DATA_W-1:0] i_wr_data,
    input  wire logic [ADDR_W-1:0]          i_rd_addr_a,
    input  wire logic [ADDR_W-1:0]          i_rd_addr_b,
    output logic      [imm_pkg::DATA_W-1:0] o_rd_a,
    output logic      [imm_pkg::DATA_W-1:0] o_rd_b
);
    import imm_pkg::*;

    logic [DATA_W-1:0] r_mem_a [DEPTH];
    logic [DATA_W-1:0] r_mem_b [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en && !i_wr_sel_b) begin
            r_mem_a[i_wr_addr] <= i_wr_data;
        end
        o_rd_a <= r_mem_a[i_rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en && i_wr_sel_b) begin
            r_mem_b[i_wr_addr] <= i_wr_data;
        end
        o_rd_b <= r_mem_b[i_rd_addr_b];
    end

endmodule

`default_nettype wire

// ===== src/imm_mac.sv =====
// multiply-accumulate pipeline: term flags aligned to read data, product, accumulate
`default_nettype none

module imm_mac (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire imm_pkg::t_term             i_term,
    input  wire logic [imm_pkg::DATA_W-1:0] i_a,
    input  wire logic [imm_pkg::DATA_W-1:0] i_b,
    output logic      [imm_pkg::DATA_W-1:0] o_acc,
    output logic                            o_done
);
    import imm_pkg::*;

    t_term             r_t1;
    t_term             r_t2;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_acc;
    logic              r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1   <= '0;
            r_t2   <= '0;
            r_done <= 1'b0;
        end else begin
            r_t1   <= i_term;
            r_t2   <= r_t1;
            r_done <= r_t2.vld && r_t2.last;
        end
    end

    // low half of the product is the same for signed and unsigned operands
    always_ff @(posedge i_clk) begin
        if (r_t1.vld) begin
            r_prod <= DATA_W'(i_a * i_b);
        end
        if (r_t2.vld) begin
            r_acc <= r_t2.first ? r_prod : r_acc + r_prod;
        end
    end

    assign o_acc  = r_acc;
    assign o_done = r_done;

endmodule

`default_nettype wire

// ===== src/integer_matrix_multiply_core.sv =====
// integer matrix multiply core: load A and B entries, then stream out A x B
// throughput: one input word per cycle for writes, taken only while the sequencer is idle; each
//   product word runs one memory read pair per term (none with inner_size 0) through one shared multiplier
// input is held off from a start until the last product word sits in the output register
// reset (synchronous, active low) restores all sizes to 8 and empties the output; stores keep data
`default_nettype none

module integer_matrix_multiply_core #(
    parameter int MAX_DIM = 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write channel
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [imm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [imm_pkg::DIM_W-1:0]     i_cfg_data,
    // input word stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [39:0]                   s_axis_tdata,  // row[2:0], column[5:3], value[37:6]
    input  wire logic [imm_pkg::ACT_W-1:0]     s_axis_tuser,  // action[1:0]
    // product word stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic      [39:0]                   m_axis_tdata,  // result_row[2:0], result_col[5:3],
                                                              // product[37:6]
    output logic                               m_axis_tlast   // last_of_run
);
    import imm_pkg::*;

    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;  // takes writes and starts
    localparam logic [1:0] S_ISSUE = 2'd1;  // one A/B read pair per cycle
    localparam logic [1:0] S_DRAIN = 2'd2;  // wait for the mac to finish the sum
    localparam logic [1:0] S_EMIT  = 2'd3;  // hand the sum to the output register

    // size registers
    logic [DIM_W-1:0] r_rows_a;
    logic [DIM_W-1:0] r_inner;
    logic [DIM_W-1:0] r_cols_b;
    logic [DIM_W-1:0] nr;
    logic [DIM_W-1:0] nk;
    logic [DIM_W-1:0] nc;

    // unpacked input word
    logic [POS_W-1:0]  in_row;
    logic [POS_W-1:0]  in_col;
    logic [DATA_W-1:0] in_value;
    logic              in_acc;
    logic              in_range;

    // sequencer
    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_i, n_i;
    logic [IDX_W-1:0] r_j, n_j;
    logic [IDX_W-1:0] r_k, n_k;
    t_term            term;
    logic             wr_en;
    logic             load_out;
    logic             last_entry;

    // store and mac
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;
    logic [DATA_W-1:0] rd_a;
    logic [DATA_W-1:0] rd_b;
    logic [DATA_W-1:0] mac_acc;
    logic              mac_done;

    // output register
    logic              r_out_valid;
    logic [POS_W-1:0]  r_out_row;
    logic [POS_W-1:0]  r_out_col;
    logic [DATA_W-1:0] r_out_prod;
    logic              r_out_last;
    logic              out_free;

    // config writes, always accepted; index beyond the list is dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= DIM_RESET;
            r_inner  <= DIM_RESET;
            r_cols_b <= DIM_RESET;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_ROWS_A) r_rows_a <= i_cfg_data;
            if (i_cfg_index == CFG_INNER)  r_inner  <= i_cfg_data;
            if (i_cfg_index == CFG_COLS_B) r_cols_b <= i_cfg_data;
        end
    end

    // sizes above the store dimension saturate
    assign nr = (r_rows_a > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_rows_a;
    assign nk = (r_inner  > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_inner;
    assign nc = (r_cols_b > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_cols_b;

    assign in_row   = s_axis_tdata[POS_W-1:0];
    assign in_col   = s_axis_tdata[2*POS_W-1:POS_W];
    assign in_value = s_axis_tdata[2*POS_W+DATA_W-1:2*POS_W];

    // stores are written only in idle, so reads of a run never meet a write
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // writes outside the store are ignored
    assign in_range = (DIM_W'(in_row) < DIM_W'(MAX_DIM)) && (DIM_W'(in_col) < DIM_W'(MAX_DIM));
    assign wr_addr  = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_DIM) + ADDR_W'(in_col));

    // row i of A and column j of B at term k
    assign rd_addr_a = ADDR_W'(ADDR_W'(r_i) * ADDR_W'(MAX_DIM) + ADDR_W'(r_k));
    assign rd_addr_b = ADDR_W'(ADDR_W'(r_k) * ADDR_W'(MAX_DIM) + ADDR_W'(r_j));

    assign out_free   = !r_out_valid || m_axis_tready;
    assign last_entry = (DIM_W'(r_i) + DIM_W'(1) == nr) && (DIM_W'(r_j) + DIM_W'(1) == nc);

    always_comb begin
        n_state  = r_state;
        n_i      = r_i;
        n_j      = r_j;
        n_k      = r_k;
        term     = '0;
        wr_en    = 1'b0;
        load_out = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (s_axis_tuser == ACT_WR_A || s_axis_tuser == ACT_WR_B) begin
                        wr_en = in_range;
                    end else if (s_axis_tuser == ACT_START &&
                                 nr != '0 && nc != '0) begin
                        n_i     = '0;
                        n_j     = '0;
                        n_k     = '0;
                        // empty inner dimension gives zero entries without reads
                        n_state = (nk == '0) ? S_EMIT : S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                term.vld   = 1'b1;
                term.first = (r_k == '0);
                term.last  = (DIM_W'(r_k) + DIM_W'(1) == nk);
                if (term.last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_k = r_k + IDX_W'(1);
                end
            end
            S_DRAIN: begin
                if (mac_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (last_entry) begin
                        n_state = S_IDLE;
                    end else begin
                        if (DIM_W'(r_j) + DIM_W'(1) == nc) begin
                            n_j = '0;
                            n_i = r_i + IDX_W'(1);
                        end else begin
                            n_j = r_j + IDX_W'(1);
                        end
                        n_k     = '0;
                        n_state = (nk == '0) ? S_EMIT : S_ISSUE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
        end
    end

    imm_store #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_wr_en     (wr_en),
        .i_wr_sel_b  (s_axis_tuser == ACT_WR_B),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (in_value),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_a      (rd_a),
        .o_rd_b      (rd_b)
    );

    imm_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_term  (term),
        .i_a     (rd_a),
        .i_b     (rd_b),
        .o_acc   (mac_acc),
        .o_done  (mac_done)
    );

    // output register lets the next entry compute while a word waits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_row  <= POS_W'(r_i);
            r_out_col  <= POS_W'(r_j);
            r_out_prod <= (nk == '0) ? '0 : mac_acc;
            r_out_last <= last_entry;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_prod, r_out_col, r_out_row};
    assign m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

// ===== src/imm_checker.sv =====
// port-level checks of the integer matrix multiply core, bound to the top level
`default_nettype none

`include "integer_matrix_multiply_core_macros.svh"

module imm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic [imm_pkg::ACT_W-1:0]     s_axis_tuser,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [39:0]                   m_axis_tdata,
    input wire logic                          m_axis_tlast
);
    import imm_pkg::*;

    // a stalled product word holds
    `IMM_ASSERT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // reset empties the output
    `IMM_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // mid-run word means the run continues, so input stays held off
    `IMM_ASSERT(a_run_holds_input, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)

    // a load or unused action never stalls the input
    `IMM_ASSERT(a_write_no_stall, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && s_axis_tuser != ACT_START |=> s_axis_tready)

endmodule

bind integer_matrix_multiply_core imm_checker u_imm_checker (.*);

`default_nettype wire
